@@ sv/kde_pkg.sv @@
// Shared constants, types and helper functions for the key debouncer with event FIFO.
`default_nettype none
package kde_pkg;

  localparam int NUM_KEYS   = 2;
  localparam int FIFO_DEPTH = 16;

  localparam int PIN_W      = 2;
  localparam int CODE_W     = 4;
  localparam int FCOUNT_W   = 5;
  localparam int KDOWN_W    = 2;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETTLE = 1'b0,
    CFG_HOLD   = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    PH_UP      = 2'd0,
    PH_PENDING = 2'd1,
    PH_DOWN    = 2'd2
  } phase_t;

  typedef struct packed {
    logic confirm;
    logic down;
  } lane_stat_t;

  typedef struct packed {
    logic                read_valid;
    logic [CODE_W-1:0]   key_code;
    logic [FCOUNT_W-1:0] fifo_count;
    logic                event_dropped;
    logic [KDOWN_W-1:0]  keys_down;
  } result_t;

  function automatic logic [TICK_W-1:0] load_value(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage
`default_nettype wire

@@ sv/kde_if.sv @@
// Valid/ready channel interfaces for the input words and the result words.
`default_nettype none
interface kde_in_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [kde_pkg::PIN_W-1:0] pin_levels;

  modport source (output valid, output command, output pin_levels, input ready);
  modport sink   (input valid, input command, input pin_levels, output ready);
endinterface

interface kde_out_if;
  logic                         valid;
  logic                         ready;
  logic                         read_valid;
  logic [kde_pkg::CODE_W-1:0]   key_code;
  logic [kde_pkg::FCOUNT_W-1:0] fifo_count;
  logic                         event_dropped;
  logic [kde_pkg::KDOWN_W-1:0]  keys_down;

  modport source (output valid, output read_valid, output key_code, output fifo_count,
                  output event_dropped, output keys_down, input ready);
  modport sink   (input valid, input read_valid, input key_code, input fifo_count,
                  input event_dropped, input keys_down, output ready);
endinterface
`default_nettype wire

@@ sv/kde_lane.sv @@
// Per-key three-phase debouncer lane with its countdown and last pin level.
`default_nettype none
module kde_lane (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       tick_en,
  input  wire logic                       pin,
  input  wire logic [kde_pkg::TICK_W-1:0] settle_ticks,
  input  wire logic [kde_pkg::TICK_W-1:0] hold_ticks,
  output kde_pkg::lane_stat_t             stat
);
  import kde_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] count_r, count_nxt;
  logic              last_r, last_nxt;
  logic [TICK_W-1:0] dec;

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    last_nxt     = last_r;
    stat.confirm = 1'b0;
    dec          = (count_r == '0) ? '0 : count_r - TICK_W'(1);
    if (tick_en) begin
      last_nxt = pin;
      case (phase_r)
        PH_PENDING, PH_DOWN: begin
          count_nxt = dec;
          if (dec == '0) begin
            if (!pin) begin
              if (phase_r == PH_PENDING) begin
                phase_nxt    = PH_DOWN;
                stat.confirm = 1'b1;
              end
              count_nxt = load_value(hold_ticks);
            end else begin
              phase_nxt = PH_UP;
            end
          end
        end
        default: begin
          phase_nxt = PH_UP;
          if (last_r && !pin) begin
            phase_nxt = PH_PENDING;
            count_nxt = load_value(settle_ticks);
          end
        end
      endcase
    end
    stat.down = (phase_nxt == PH_DOWN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_UP;
      count_r <= '0;
      last_r  <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/kde_fifo.sv @@
// Event FIFO that merges lane confirmations in ascending key order and serves reads.
`default_nettype none
module kde_fifo (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_en,
  input  wire logic [kde_pkg::NUM_KEYS-1:0] push_req,
  output logic                              read_valid,
  output logic [kde_pkg::CODE_W-1:0]        key_code,
  output logic [kde_pkg::CNT_W-1:0]         count_next,
  output logic                              dropped
);
  import kde_pkg::*;

  logic [CODE_W-1:0] store [FIFO_DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NUM_KEYS-1:0] wr_en;
  logic [PTR_W-1:0]  wr_addr [NUM_KEYS];

  always_comb begin
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    cnt_nxt    = cnt_r;
    read_valid = 1'b0;
    key_code   = '0;
    dropped    = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      wr_en[k]   = 1'b0;
      wr_addr[k] = '0;
    end
    if (rd_en) begin
      if (cnt_r != '0) begin
        read_valid = 1'b1;
        key_code   = store[rp_r];
        rp_nxt     = ptr_inc(rp_r);
        cnt_nxt    = cnt_r - CNT_W'(1);
      end
    end else begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (push_req[k]) begin
          if (cnt_nxt < CNT_W'(FIFO_DEPTH)) begin
            wr_en[k]   = 1'b1;
            wr_addr[k] = wp_nxt;
            wp_nxt     = ptr_inc(wp_nxt);
            cnt_nxt    = cnt_nxt + CNT_W'(1);
          end else begin
            dropped = 1'b1;
          end
        end
      end
    end
    count_next = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (wr_en[k]) begin
        store[wr_addr[k]] <= CODE_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/key_debounce_event_fifo.sv @@
// Top level: debouncer lanes, event FIFO, configuration registers and output buffer.
// Lanes and FIFO update in the accepting cycle; the result word is then registered.
// Throughput is one word per cycle while the skid entry of the output buffer is empty.
// A two-entry output buffer keeps input ready high while one result waits downstream.
// Synchronous active-low reset clears the lanes, FIFO pointers and buffer valid flags,
// and loads the register defaults; FIFO entry contents are not reset.
`default_nettype none
module key_debounce_event_fifo (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  kde_in_if.sink                              in_ch,
  kde_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [kde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kde_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import kde_pkg::*;

  logic [TICK_W-1:0] settle_r, hold_r;
  logic              accept, tick_en, rd_en;
  lane_stat_t        stat [NUM_KEYS];
  logic [NUM_KEYS-1:0] push_req;
  logic [KDOWN_W-1:0]  keys_down;
  logic              f_read_valid, f_dropped;
  logic [CODE_W-1:0] f_code;
  logic [CNT_W-1:0]  f_count;
  result_t           res;
  result_t           out_r, out_nxt, skid_r, skid_nxt;
  logic              out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && !skid_valid_r;
  assign tick_en     = accept && (in_ch.command == CMD_TICK);
  assign rd_en       = accept && (in_ch.command == CMD_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= TICK_W'(1);
      hold_r   <= TICK_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETTLE: settle_r <= cfg_wdata[TICK_W-1:0];
        CFG_HOLD:   hold_r   <= cfg_wdata[TICK_W-1:0];
        default:    ;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic pin;
    if (k < PIN_W) begin : g_pin
      assign pin = in_ch.pin_levels[k];
    end else begin : g_nopin
      assign pin = 1'b0;
    end
    kde_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .tick_en      (tick_en),
      .pin          (pin),
      .settle_ticks (settle_r),
      .hold_ticks   (hold_r),
      .stat         (stat[k])
    );
    assign push_req[k] = stat[k].confirm;
  end

  for (genvar i = 0; i < KDOWN_W; i++) begin : g_kd
    if (i < NUM_KEYS) begin : g_on
      assign keys_down[i] = stat[i].down;
    end else begin : g_off
      assign keys_down[i] = 1'b0;
    end
  end

  kde_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (rd_en),
    .push_req   (push_req),
    .read_valid (f_read_valid),
    .key_code   (f_code),
    .count_next (f_count),
    .dropped    (f_dropped)
  );

  always_comb begin
    res.read_valid    = f_read_valid;
    res.key_code      = f_code;
    res.fifo_count    = FCOUNT_W'(f_count);
    res.event_dropped = f_dropped;
    res.keys_down     = keys_down;
  end

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_valid_r && out_ch.ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (accept) begin
      if (!out_valid_nxt) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_valid    = out_r.read_valid;
  assign out_ch.key_code      = out_r.key_code;
  assign out_ch.fifo_count    = out_r.fifo_count;
  assign out_ch.event_dropped = out_r.event_dropped;
  assign out_ch.keys_down     = out_r.keys_down;

endmodule
`default_nettype wire
